/* src/trn_pkg.sv */
`default_nettype none
package trn_pkg;

    // coordinate width used when the top level is not overridden
    localparam int COORD_BITS_DEFAULT = 16;

    // unit scale is 2^Q_BITS - 1, so its square is 2^(2Q) - 2^(Q+1) + 1
    localparam int Q_BITS    = 15;
    localparam int NORM_BITS = Q_BITS + 1;

    // three vector components per corner and per normal
    localparam int LANES = 3;

endpackage
`default_nettype wire

/* src/trn_corner_if.sv */
`default_nettype none
interface trn_corner_if #(
    parameter int COORD_BITS = trn_pkg::COORD_BITS_DEFAULT
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] a_x;
    logic signed [COORD_BITS-1:0] a_y;
    logic signed [COORD_BITS-1:0] a_z;
    logic signed [COORD_BITS-1:0] b_x;
    logic signed [COORD_BITS-1:0] b_y;
    logic signed [COORD_BITS-1:0] b_z;
    logic signed [COORD_BITS-1:0] c_x;
    logic signed [COORD_BITS-1:0] c_y;
    logic signed [COORD_BITS-1:0] c_z;

    modport source (
        output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
        input  ready
    );
    modport sink (
        input  valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
        output ready
    );
endinterface
`default_nettype wire

/* src/trn_normal_if.sv */
`default_nettype none
interface trn_normal_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [trn_pkg::NORM_BITS-1:0]   norm_x;
    logic signed [trn_pkg::NORM_BITS-1:0]   norm_y;
    logic signed [trn_pkg::NORM_BITS-1:0]   norm_z;
    logic                                   degenerate;

    modport source (
        output valid, norm_x, norm_y, norm_z, degenerate,
        input  ready
    );
    modport sink (
        input  valid, norm_x, norm_y, norm_z, degenerate,
        output ready
    );
endinterface
`default_nettype wire

/* src/triangle_unit_normal.sv */
`default_nettype none
// Triangle unit normal, fully pipelined.
// Throughput: one triangle per cycle while the output is not stalled.
// The 15 digit stages of the exact normalization (one quotient bit per stage,
// three lanes) set the depth.
// A stall on the output freezes every stage; nothing is dropped or repeated.
// Reset (rst_n, async, active low) clears all stage valid bits only.
module triangle_unit_normal #(
    parameter int COORD_BITS = trn_pkg::COORD_BITS_DEFAULT
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    trn_corner_if.sink        corners,
    trn_normal_if.source      normal
);

    localparam int QB  = trn_pkg::Q_BITS;
    localparam int NB  = trn_pkg::NORM_BITS;
    localparam int L   = trn_pkg::LANES;
    localparam int EW  = COORD_BITS + 1;     // edge vector
    localparam int PW  = 2 * EW;             // edge product
    localparam int NW  = PW + 1;             // signed cross component
    localparam int MW  = PW;                 // cross magnitude
    localparam int LO  = MW / 2;
    localparam int HI  = MW - LO;
    localparam int SQW = 2 * MW;             // squared component
    localparam int SW  = SQW + 2;            // squared length
    localparam int AW  = SW + 2 * QB + 2;    // digit recurrence width

    // global advance: every stage moves when the last one can drain
    logic adv;
    logic v_last;

    assign adv           = !v_last || normal.ready;
    assign corners.ready = adv;

    // stage 1: edge vectors from corner A
    logic signed [COORD_BITS-1:0] ca [L];
    logic signed [COORD_BITS-1:0] cb [L];
    logic signed [COORD_BITS-1:0] cc [L];
    logic signed [EW-1:0]         e1_reg [L];
    logic signed [EW-1:0]         e2_reg [L];
    logic                         v1_reg;

    always_comb
    begin
        ca[0] = corners.a_x; ca[1] = corners.a_y; ca[2] = corners.a_z;
        cb[0] = corners.b_x; cb[1] = corners.b_y; cb[2] = corners.b_z;
        cc[0] = corners.c_x; cc[1] = corners.c_y; cc[2] = corners.c_z;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int j = 0; j < L; j++)
            begin
                e1_reg[j] <= EW'(cb[j]) - EW'(ca[j]);
                e2_reg[j] <= EW'(cc[j]) - EW'(ca[j]);
            end
        end
    end

    // stage 2: the six cross products
    logic signed [PW-1:0] pa_reg [L];
    logic signed [PW-1:0] pb_reg [L];
    logic                 v2_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pa_reg[0] <= e1_reg[1] * e2_reg[2];
            pb_reg[0] <= e1_reg[2] * e2_reg[1];
            pa_reg[1] <= e1_reg[2] * e2_reg[0];
            pb_reg[1] <= e1_reg[0] * e2_reg[2];
            pa_reg[2] <= e1_reg[0] * e2_reg[1];
            pb_reg[2] <= e1_reg[1] * e2_reg[0];
        end
    end

    // stage 3: cross components, split into sign and magnitude
    logic signed [NW-1:0] xprod [L];
    logic [MW-1:0]        mag_next [L];
    logic [MW-1:0]        mag_reg [L];
    logic [L-1:0]         sg3_reg;
    logic                 dg3_reg;
    logic                 v3_reg;

    always_comb
    begin
        for (int j = 0; j < L; j++)
        begin
            xprod[j]    = NW'(pa_reg[j]) - NW'(pb_reg[j]);
            mag_next[j] = xprod[j][NW-1] ? MW'(-xprod[j]) : MW'(xprod[j]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int j = 0; j < L; j++)
            begin
                mag_reg[j] <= mag_next[j];
                sg3_reg[j] <= xprod[j][NW-1];
            end
            dg3_reg <= (xprod[0] == '0) && (xprod[1] == '0) && (xprod[2] == '0);
        end
    end

    // stage 4: partial products of each square
    logic [2*HI-1:0]  hh_reg [L];
    logic [HI+LO-1:0] hl_reg [L];
    logic [2*LO-1:0]  ll_reg [L];
    logic [L-1:0]     sg4_reg;
    logic             dg4_reg;
    logic             v4_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int j = 0; j < L; j++)
            begin
                hh_reg[j] <= mag_reg[j][MW-1:LO] * mag_reg[j][MW-1:LO];
                hl_reg[j] <= mag_reg[j][MW-1:LO] * mag_reg[j][LO-1:0];
                ll_reg[j] <= mag_reg[j][LO-1:0] * mag_reg[j][LO-1:0];
            end
            sg4_reg <= sg3_reg;
            dg4_reg <= dg3_reg;
        end
    end

    // stage 5: squared components
    logic [SQW-1:0] c2_reg [L];
    logic [L-1:0]   sg5_reg;
    logic           dg5_reg;
    logic           v5_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int j = 0; j < L; j++)
            begin
                c2_reg[j] <= (SQW'(hh_reg[j]) << (2 * LO))
                           + (SQW'(hl_reg[j]) << (LO + 1))
                           + SQW'(ll_reg[j]);
            end
            sg5_reg <= sg4_reg;
            dg5_reg <= dg4_reg;
        end
    end

    // digit stages: index 0 holds the start values, index QB the finished quotient.
    // r = scale^2*c^2 - q^2*S, y = q*S
    logic [AW-1:0] r_reg [QB+1][L];
    logic [AW-1:0] y_reg [QB+1][L];
    logic [QB-1:0] q_reg [QB+1][L];
    logic [SW-1:0] s_reg [QB+1];
    logic [L-1:0]  sg_reg [QB+1];
    logic          dg_reg [QB+1];
    logic          v_reg [QB+1];

    // stage 6: squared length and scaled squares
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int j = 0; j < L; j++)
            begin
                r_reg[0][j] <= (AW'(c2_reg[j]) << (2 * QB))
                             - (AW'(c2_reg[j]) << (QB + 1))
                             + AW'(c2_reg[j]);
                y_reg[0][j] <= '0;
                q_reg[0][j] <= '0;
            end
            s_reg[0]  <= SW'(c2_reg[0]) + SW'(c2_reg[1]) + SW'(c2_reg[2]);
            sg_reg[0] <= sg5_reg;
            dg_reg[0] <= dg5_reg;
        end
    end

    // one quotient bit per stage, all three lanes side by side
    for (genvar i = 0; i < QB; i++)
    begin : g_digit
        localparam int K = QB - 1 - i;

        logic [AW-1:0] d [L];
        logic [L-1:0]  take;

        always_comb
        begin
            for (int j = 0; j < L; j++)
            begin
                d[j]    = (y_reg[i][j] << (K + 1)) + (AW'(s_reg[i]) << (2 * K));
                take[j] = (d[j] <= r_reg[i][j]);
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                for (int j = 0; j < L; j++)
                begin
                    if (take[j])
                    begin
                        r_reg[i+1][j] <= r_reg[i][j] - d[j];
                        y_reg[i+1][j] <= y_reg[i][j] + (AW'(s_reg[i]) << K);
                        q_reg[i+1][j] <= q_reg[i][j] | (QB'(1) << K);
                    end
                    else
                    begin
                        r_reg[i+1][j] <= r_reg[i][j];
                        y_reg[i+1][j] <= y_reg[i][j];
                        q_reg[i+1][j] <= q_reg[i][j];
                    end
                end
                s_reg[i+1]  <= s_reg[i];
                sg_reg[i+1] <= sg_reg[i];
                dg_reg[i+1] <= dg_reg[i];
            end
        end
    end

    // valid bits for every stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            for (int i = 0; i <= QB; i++)
            begin
                v_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            v1_reg   <= corners.valid;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            v4_reg   <= v3_reg;
            v5_reg   <= v4_reg;
            v_reg[0] <= v5_reg;
            for (int i = 0; i < QB; i++)
            begin
                v_reg[i+1] <= v_reg[i];
            end
        end
    end

    // result beat: apply sign, force zero on a degenerate triangle
    logic signed [NB-1:0] norm [L];

    always_comb
    begin
        for (int j = 0; j < L; j++)
        begin
            if (dg_reg[QB])
                norm[j] = '0;
            else if (sg_reg[QB][j])
                norm[j] = -$signed({1'b0, q_reg[QB][j]});
            else
                norm[j] = $signed({1'b0, q_reg[QB][j]});
        end
    end

    assign v_last            = v_reg[QB];
    assign normal.valid      = v_reg[QB];
    assign normal.norm_x     = norm[0];
    assign normal.norm_y     = norm[1];
    assign normal.norm_z     = norm[2];
    assign normal.degenerate = dg_reg[QB];

`ifndef NO_ASSERTIONS
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (normal.valid && normal.degenerate) |->
            (normal.norm_x == '0 && normal.norm_y == '0 && normal.norm_z == '0))
        else $error("degenerate beat with nonzero normal");

    // largest component of a unit vector is at least 1/sqrt(3)
    a_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (normal.valid && !normal.degenerate) |->
            (normal.norm_x != '0 || normal.norm_y != '0 || normal.norm_z != '0))
        else $error("nondegenerate beat with zero normal");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        normal.valid |->
            (normal.norm_x != {1'b1, {(NB-1){1'b0}}} &&
             normal.norm_y != {1'b1, {(NB-1){1'b0}}} &&
             normal.norm_z != {1'b1, {(NB-1){1'b0}}}))
        else $error("normal component out of range");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> ($stable(v_reg[0]) && $stable(v1_reg) && $stable(v5_reg)))
        else $error("pipeline moved while stalled");
`endif

endmodule
`default_nettype wire

/* tb/sv/triangle_unit_normal_tb.sv */
module triangle_unit_normal_tb;

    localparam int CB          = trn_pkg::COORD_BITS_DEFAULT;
    localparam int LATENCY     = 21;
    localparam int IDLE_LIMIT  = 20000;
    localparam int N_RANDOM    = 1700;

    typedef logic signed [CB-1:0]                 coord_t;
    typedef logic signed [trn_pkg::NORM_BITS-1:0] norm_t;

    typedef struct packed {
        norm_t nx;
        norm_t ny;
        norm_t nz;
        logic  degen;
    } normal_t;

    // scoreboard: predicts each triangle's unit normal and checks results in order
    class normal_scoreboard;
        normal_t pending[$];
        int      errors;

        function new();
            errors = 0;
        endfunction

        // largest q with q*q*s <= 32767^2 * c^2, sign of c
        function norm_t unit_part(longint c, logic [127:0] s);
            logic [127:0] mag;
            logic [127:0] rhs;
            logic [127:0] lhs;
            logic [14:0]  q;
            logic [14:0]  t;
            mag = (c < 0) ? -c : c;
            rhs = mag * mag * 128'd1073676289;
            q = '0;
            for (int b = 14; b >= 0; b--)
            begin
                t = q | (15'd1 << b);
                lhs = s * t * t;
                if (lhs <= rhs)
                    q = t;
            end
            return (c < 0) ? -norm_t'({1'b0, q}) : norm_t'({1'b0, q});
        endfunction

        function void note_triangle(coord_t v[9]);
            longint              e1[3];
            longint              e2[3];
            longint              n[3];
            logic signed [127:0] w[3];
            logic [127:0]        s;
            normal_t             r;
            for (int i = 0; i < 3; i++)
            begin
                e1[i] = longint'(v[3+i]) - longint'(v[i]);
                e2[i] = longint'(v[6+i]) - longint'(v[i]);
            end
            n[0] = e1[1]*e2[2] - e1[2]*e2[1];
            n[1] = e1[2]*e2[0] - e1[0]*e2[2];
            n[2] = e1[0]*e2[1] - e1[1]*e2[0];
            if (n[0] == 0 && n[1] == 0 && n[2] == 0)
                r = '{nx: 0, ny: 0, nz: 0, degen: 1'b1};
            else
            begin
                // squares need more than 64 bits
                for (int i = 0; i < 3; i++)
                    w[i] = n[i];
                s = w[0]*w[0] + w[1]*w[1] + w[2]*w[2];
                r.nx = unit_part(n[0], s);
                r.ny = unit_part(n[1], s);
                r.nz = unit_part(n[2], s);
                r.degen = 1'b0;
            end
            pending.push_back(r);
        endfunction

        task check_normal(normal_t got);
            normal_t want;
            if (pending.size() == 0)
            begin
                report("unexpected beat", 0, got);
                return;
            end
            want = pending.pop_front();
            if (got.nx !== want.nx)       report("norm_x", want, got);
            if (got.ny !== want.ny)       report("norm_y", want, got);
            if (got.nz !== want.nz)       report("norm_z", want, got);
            if (got.degen !== want.degen) report("degenerate", want, got);
        endtask

        task report(string what, normal_t want, normal_t got);
            errors++;
            if (errors <= 40)
                $display("mismatch %s: want %0d %0d %0d %0b got %0d %0d %0d %0b", what,
                         want.nx, want.ny, want.nz, want.degen,
                         got.nx, got.ny, got.nz, got.degen);
        endtask
    endclass

    logic clk;
    logic rst_n;

    trn_corner_if #(.COORD_BITS(CB)) corners();
    trn_normal_if                    normal();

    triangle_unit_normal #(.COORD_BITS(CB)) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .corners (corners.sink),
        .normal  (normal.source)
    );

    normal_scoreboard sb;
    int  idle_cycles;
    bit  stim_done;
    bit  long_hold;

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // short gaps mostly, long ones now and then
    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic coord_t rand_coord(int style);
        case (style)
            0: return coord_t'($urandom);
            1: return coord_t'(int'($urandom_range(0, 30)) - 15);
            2: return ($urandom_range(0, 1)) ? 16'sh7fff : 16'sh8000;
            default: return coord_t'(int'($urandom_range(0, 2000)) - 1000);
        endcase
    endfunction

    task automatic send_triangle(coord_t v[9]);
        corners.valid <= 1'b1;
        corners.a_x <= v[0]; corners.a_y <= v[1]; corners.a_z <= v[2];
        corners.b_x <= v[3]; corners.b_y <= v[4]; corners.b_z <= v[5];
        corners.c_x <= v[6]; corners.c_y <= v[7]; corners.c_z <= v[8];
        do @(posedge clk); while (!corners.ready);
        sb.note_triangle(v);
    endtask

    task automatic send_with_gap(coord_t v[9]);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            corners.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        send_triangle(v);
    endtask

    // sender
    initial
    begin
        coord_t v[9];
        int     style;
        sb = new();
        rst_n <= 1'b0;
        corners.valid <= 1'b0;
        {corners.a_x, corners.a_y, corners.a_z} <= '0;
        {corners.b_x, corners.b_y, corners.b_z} <= '0;
        {corners.c_x, corners.c_y, corners.c_z} <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: axis triangles, extremes, degenerate cases
        v = '{0,0,0, 1,0,0, 0,1,0};                      send_triangle(v);
        v = '{0,0,0, 0,1,0, 1,0,0};                      send_triangle(v);
        v = '{0,0,0, 0,1,0, 0,0,1};                      send_triangle(v);
        v = '{0,0,0, 0,0,1, 1,0,0};                      send_triangle(v);
        v = '{5,5,5, 5,5,5, 5,5,5};                      send_triangle(v);
        v = '{0,0,0, 1,1,1, 2,2,2};                      send_triangle(v);
        v = '{-32768,-32768,-32768, 32767,-32768,-32768, -32768,32767,-32768};
        send_triangle(v);
        v = '{32767,32767,32767, -32768,32767,32767, 32767,-32768,32767};
        send_triangle(v);
        v = '{-32768,-32768,-32768, 32767,32767,-32768, -32768,32767,32767};
        send_triangle(v);
        v = '{32767,-32768,0, -32768,32767,0, 0,0,32767};  send_triangle(v);
        v = '{-32768,-32768,-32768, 32767,32767,32767, -32768,-32768,-32768};
        send_triangle(v);
        v = '{0,0,0, 1,2,3, 4,5,6};                      send_triangle(v);
        v = '{0,0,0, 1,1,0, 1,0,1};                      send_triangle(v);
        v = '{0,0,0, 32767,1,0, 0,1,32767};              send_triangle(v);
        v = '{-1,-1,-1, 0,-1,-1, -1,0,-1};               send_triangle(v);
        v = '{16'sh5555,16'sh2aaa,16'sh7fff, 16'sh8000,16'sh1234,16'shfedc,
              16'sh0001,16'shffff,16'sh4000};             send_triangle(v);

        // random: mixed magnitude styles, some degenerate
        for (int n = 0; n < N_RANDOM; n++)
        begin
            style = $urandom_range(0, 3);
            for (int i = 0; i < 9; i++)
                v[i] = rand_coord(style);
            if ($urandom_range(0, 19) == 0)
                for (int i = 0; i < 3; i++)
                    v[6+i] = coord_t'(int'(v[i]) + 2 * (int'(v[3+i]) - int'(v[i])));
            if (n == 300)
                long_hold = 1'b1;
            if (long_hold && n < 400)
                send_triangle(v);
            else
                send_with_gap(v);
        end
        corners.valid <= 1'b0;
        stim_done = 1'b1;
    end

    // receiver: random stalls, one long hold-off while the sender keeps offering
    initial
    begin
        normal.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold)
            begin
                long_hold = 1'b0;
                normal.ready <= 1'b0;
                repeat (200) @(posedge clk);
            end
            if ($urandom_range(0, 99) < 20)
            begin
                normal.ready <= 1'b0;
                repeat (gap_len()) @(posedge clk);
            end
            normal.ready <= 1'b1;
        end
    end

    // result check
    always @(posedge clk)
    begin
        if (rst_n && normal.valid && normal.ready)
            sb.check_normal('{normal.norm_x, normal.norm_y, normal.norm_z,
                              normal.degenerate});
    end

    // watchdog on accepted beats, ends the run on a hang
    always @(posedge clk)
    begin
        if (!rst_n || (corners.valid && corners.ready) || (normal.valid && normal.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (rst_n && idle_cycles >= IDLE_LIMIT)
        begin
            $display("[triangle_unit_normal] ERROR");
            $finish;
        end
    end

    // end of run
    initial
    begin
        wait (stim_done);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("[triangle_unit_normal] OK");
        else
            $display("[triangle_unit_normal] ERROR");
        $finish;
    end

endmodule
